>>> src/frr_pkg.sv
// Shared widths, command codes and helpers for the range-add/range-sum store.
// No dependencies; imported by every module of the block.
package frr_pkg;

  localparam int DATA_W            = 64;
  localparam int SIZE_W            = 11;
  // Walk positions reach twice the largest 11-bit size; two more bits cover that.
  localparam int POS_W             = SIZE_W + 2;
  localparam int MAX_POSITIONS_DEF = 1024;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  // Lowest set bit of a position, the step of a tree walk.
  function automatic logic [POS_W-1:0] lowbit(input logic [POS_W-1:0] p);
    lowbit = p & (~p + POS_W'(1));
  endfunction

endpackage

>>> src/frr_ram.sv
// Simple dual-port memory: one write port, one read port, registered read data.
// Depends on frr_pkg for the data width.
module frr_ram #(
  parameter int DEPTH = frr_pkg::MAX_POSITIONS_DEF + 1,
  parameter int AW    = $clog2(frr_pkg::MAX_POSITIONS_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [frr_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [frr_pkg::DATA_W-1:0] rdata
);
  import frr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/fenwick_range_add_range_sum_top.sv
// Top level of the range-add/range-sum store built on two binary indexed trees.
// Depends on frr_pkg and instantiates two frr_ram memories.
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+--------------------------------
//  command  | start, busy, cmd, left, right,   | start high while busy is low
//           | value                            |
//  result   | done, range_sum                  | done high for one cycle
//  config   | cfg_valid, cfg_ready, cfg_data   | cfg_valid and cfg_ready high
//
// After reset a clearing pass writes zero to all MAX_POSITIONS+1 entries of both
// trees, one entry per cycle, with busy high. An add walks upward from left, then
// from right+1: per walk a multiply step, one update per entry and a drain. A sum
// walks downward from right, then from left-1: per walk the entry reads, a drain,
// a multiply and an accumulate. A dropped item leaves busy low; the receiver
// cannot stall.
module fenwick_range_add_range_sum_top #(
  parameter int MAX_POSITIONS = frr_pkg::MAX_POSITIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [frr_pkg::SIZE_W-1:0]        left,
  input  logic [frr_pkg::SIZE_W-1:0]        right,
  input  logic signed [frr_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic signed [frr_pkg::DATA_W-1:0] range_sum,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [frr_pkg::SIZE_W-1:0]        cfg_data
);
  import frr_pkg::*;

  localparam int DEPTH = MAX_POSITIONS + 1;
  localparam int AW    = $clog2(MAX_POSITIONS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_ADD_MUL = 3'd2;
  localparam logic [2:0] S_UP      = 3'd3;
  localparam logic [2:0] S_DOWN    = 3'd4;
  localparam logic [2:0] S_SUM_MUL = 3'd5;
  localparam logic [2:0] S_SUM_ACC = 3'd6;

  logic [2:0]        state;
  logic              phase;
  logic [SIZE_W-1:0] size_in_use;
  logic [POS_W-1:0]  n;
  logic [POS_W-1:0]  lft;
  logic [POS_W-1:0]  rgt;
  logic [DATA_W-1:0] x;
  logic [POS_W-1:0]  pos;
  logic              pend;
  logic [AW-1:0]     pend_addr;
  logic [DATA_W-1:0] amt_d;
  logic [DATA_W-1:0] amt_w;
  logic [DATA_W-1:0] s1;
  logic [DATA_W-1:0] s2;
  logic [DATA_W-1:0] tot;
  logic [DATA_W-1:0] prod;
  logic [AW-1:0]     clr_addr;

  logic [POS_W-1:0]  n_eff;
  logic [POS_W-1:0]  l_in;
  logic [POS_W-1:0]  r_in;
  logic              ok;
  logic              up_in_range;
  logic [POS_W-1:0]  mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [DATA_W-1:0] mul_out;
  logic [DATA_W-1:0] sum_diff;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] wd_d;
  logic [DATA_W-1:0] wd_w;
  logic [DATA_W-1:0] q_d;
  logic [DATA_W-1:0] q_w;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // A size above the tree capacity is saturated to the capacity.
  always_comb begin
    if (32'(size_in_use) > 32'(MAX_POSITIONS)) begin
      n_eff = POS_W'(MAX_POSITIONS);
    end else begin
      n_eff = POS_W'(size_in_use);
    end
  end

  assign l_in = POS_W'(left);
  assign r_in = POS_W'(right);
  assign ok   = (l_in != '0) && (l_in <= r_in) && (r_in <= n_eff);

  assign up_in_range = (pos != '0) && (pos <= n);

  // One shared multiplier: weighted amounts for adds, (p+1)*S1 for sums.
  always_comb begin
    if (state == S_ADD_MUL) begin
      mul_a = phase ? (rgt + POS_W'(1)) : lft;
      mul_b = x;
    end else begin
      mul_a = phase ? lft : (rgt + POS_W'(1));
      mul_b = s1;
    end
  end
  assign mul_out  = mul_b * DATA_W'(mul_a);
  assign sum_diff = prod - s2;

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr;
    raddr = AW'(pos);
    wd_d  = q_d + amt_d;
    wd_w  = q_w + amt_w;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wd_d  = '0;
        wd_w  = '0;
      end
      S_UP: begin
        we = pend;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  frr_ram #(.DEPTH(DEPTH), .AW(AW)) u_diff_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd_d),
    .raddr (raddr),
    .rdata (q_d)
  );

  frr_ram #(.DEPTH(DEPTH), .AW(AW)) u_weighted_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wd_w),
    .raddr (raddr),
    .rdata (q_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      phase       <= 1'b0;
      pend        <= 1'b0;
      done        <= 1'b0;
      clr_addr    <= '0;
      size_in_use <= SIZE_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        size_in_use <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            lft   <= l_in;
            rgt   <= r_in;
            x     <= value;
            n     <= n_eff;
            phase <= 1'b0;
            pend  <= 1'b0;
            if (!ok) begin
              // A dropped sum still returns one result of zero.
              if (cmd == CMD_SUM) begin
                done      <= 1'b1;
                range_sum <= '0;
              end
            end else if (cmd == CMD_ADD) begin
              state <= S_ADD_MUL;
            end else begin
              pos   <= r_in;
              s1    <= '0;
              s2    <= '0;
              state <= S_DOWN;
            end
          end
        end
        S_ADD_MUL: begin
          amt_d <= phase ? (DATA_W'(0) - x) : x;
          amt_w <= phase ? (DATA_W'(0) - mul_out) : mul_out;
          pos   <= phase ? (rgt + POS_W'(1)) : lft;
          pend  <= 1'b0;
          state <= S_UP;
        end
        S_UP: begin
          // Positions rise strictly within a walk, so the write of one entry
          // never meets the read of the next; the walk drains before the next.
          if (up_in_range) begin
            pend      <= 1'b1;
            pend_addr <= AW'(pos);
            pos       <= pos + lowbit(pos);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (phase) begin
                state <= S_IDLE;
              end else begin
                phase <= 1'b1;
                state <= S_ADD_MUL;
              end
            end
          end
        end
        S_DOWN: begin
          if (pos != '0) begin
            pend <= 1'b1;
            pos  <= pos - lowbit(pos);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            s1 <= s1 + q_d;
            s2 <= s2 + q_w;
          end
          if ((pos == '0) && !pend) begin
            state <= S_SUM_MUL;
          end
        end
        S_SUM_MUL: begin
          prod  <= mul_out;
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          if (!phase) begin
            tot   <= sum_diff;
            phase <= 1'b1;
            pos   <= lft - POS_W'(1);
            s1    <= '0;
            s2    <= '0;
            pend  <= 1'b0;
            state <= S_DOWN;
          end else begin
            range_sum <= tot - sum_diff;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
